>>> hw/rtl/pulse_count_backlight_dimmer_defines.svh
// assertion macros of the dimmer rtl, used by pcbd_datapath
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef PULSE_COUNT_BACKLIGHT_DIMMER_DEFINES_SVH
`define PULSE_COUNT_BACKLIGHT_DIMMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PCBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcbd: same-cycle check failed");
// next-cycle implication
`define PCBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcbd: next-cycle check failed");
`else
`define PCBD_ASSERT_IMP(lbl, ante, cons)
`define PCBD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/pcbd_pkg.sv
// shared constants, codes and types of the pulse-count dimmer
// no dependencies
`timescale 1ns / 1ps

package pcbd_pkg;

    localparam int NUM_STEPS_DEF = 16;
    localparam int FULL_SCALE    = 768;
    localparam int BOOT_STEP     = 5;

    localparam int BRIGHT_W   = 10;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD   = 2'd3;

    // register reset values
    localparam logic [HOLD_W-1:0] START_HOLD_RST = 16'd30;
    localparam logic [HOLD_W-1:0] PULSE_LOW_RST  = 16'd2;
    localparam logic [HOLD_W-1:0] PULSE_HIGH_RST = 16'd1;
    localparam logic [HOLD_W-1:0] OFF_HOLD_RST   = 16'd3000;

    // pin action to load into the output register
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OFF,
        ACT_START,
        ACT_LOW,
        ACT_HIGH
    } pcbd_act_t;

    typedef struct packed {
        logic      capture;
        logic      start;
        pcbd_act_t act;
    } pcbd_cmd_t;

    typedef struct packed {
        logic is_off;
        logic unchanged;
        logic was_on;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } pcbd_stat_t;

endpackage

>>> hw/rtl/pcbd_if.sv
// request and pin-action channel interfaces of the dimmer
// depends on pcbd_pkg
`timescale 1ns / 1ps

interface pcbd_req_if;
    import pcbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [BRIGHT_W-1:0] brightness;

    modport source (output valid, output brightness, input ready);
    modport sink (input valid, input brightness, output ready);
endinterface

interface pcbd_act_if;
    import pcbd_pkg::*;

    logic              valid;
    logic              ready;
    logic              pin_level;
    logic [HOLD_W-1:0] hold_us;
    logic              last_action;

    modport source (output valid, output pin_level, output hold_us, output last_action,
                    input ready);
    modport sink (input valid, input pin_level, input hold_us, input last_action,
                  output ready);
endinterface

>>> hw/rtl/pulse_count_backlight_dimmer.sv
// pulse-count dimmer for a single-wire led driver
// depends on pcbd_pkg, pcbd_req_if, pcbd_act_if, pcbd_ctrl and pcbd_datapath
`timescale 1ns / 1ps
//
// usage:
// - req carries one brightness request (0 is off); it is taken when valid and ready
//   are both high, and ready is high only while no request is being worked on
// - act carries the pin actions of a request: level, hold time, and a last flag
//   on the final action of the run; an unchanged step gives no actions at all
// - the four timing registers are written on cfg_we with cfg_index/cfg_data; the user
//   must write them only while the block is idle, which the block does not enforce
// sequence and throughput:
// - the request is taken and mapped in the idle state, decided in the decide state,
//   then one action per cycle goes into the output register while it is free,
//   paced by the single action sequencer
// - ready returns as the last action is loaded, so the next request overlaps
//   with that action waiting in the output register
// reset:
// - timing registers take their defaults, the driver is taken as on at the
//   boot step (5, capped at NUM_STEPS), and the output register is empty
// stalls:
// - while act ready is low the output register holds its action and the
//   sequencer waits; nothing is dropped or repeated
//
module pulse_count_backlight_dimmer #(
    parameter int NUM_STEPS = pcbd_pkg::NUM_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    pcbd_req_if.sink                          req,
    pcbd_act_if.source                        act
);
    import pcbd_pkg::*;

    pcbd_cmd_t  cmd;
    pcbd_stat_t stat;

    pcbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcbd_datapath #(
        .NUM_STEPS (NUM_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .brightness  (req.brightness),
        .cmd         (cmd),
        .stat        (stat),
        .act_ready   (act.ready),
        .act_valid   (act.valid),
        .pin_level   (act.pin_level),
        .hold_us     (act.hold_us),
        .last_action (act.last_action)
    );

endmodule

>>> hw/rtl/pcbd_ctrl.sv
// sequencer of the dimmer: walks each request through its run of pin actions
// depends on pcbd_pkg
`timescale 1ns / 1ps

module pcbd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  pcbd_pkg::pcbd_stat_t   stat,
    output pcbd_pkg::pcbd_cmd_t    cmd
);
    import pcbd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_OFF,
        ST_START,
        ST_LOW,
        ST_HIGH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.start   = 1'b0;
        cmd.act     = ACT_NONE;
        req_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.is_off)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_OFF;
                end
                else if (stat.unchanged)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.was_on ? ST_LOW : ST_START;
                end
            end
            ST_OFF:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = ACT_OFF;
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = ACT_START;
                    state_next = stat.cnt_zero ? ST_IDLE : ST_LOW;
                end
            end
            ST_LOW:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = ACT_LOW;
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = ACT_HIGH;
                    state_next = stat.cnt_one ? ST_IDLE : ST_LOW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/pcbd_datapath.sv
// dimmer datapath: timing registers, step mapping, driver state, pulse counter, output register
// depends on pcbd_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "pulse_count_backlight_dimmer_defines.svh"

module pcbd_datapath #(
    parameter int NUM_STEPS = pcbd_pkg::NUM_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [pcbd_pkg::BRIGHT_W-1:0]     brightness,
    input  pcbd_pkg::pcbd_cmd_t               cmd,
    output pcbd_pkg::pcbd_stat_t              stat,
    input  logic                              act_ready,
    output logic                              act_valid,
    output logic                              pin_level,
    output logic [pcbd_pkg::HOLD_W-1:0]       hold_us,
    output logic                              last_action
);
    import pcbd_pkg::*;

    localparam int SPAN   = FULL_SCALE / NUM_STEPS;
    localparam int STEP_W = $clog2(NUM_STEPS + 1);
    localparam int CNT_W  = (NUM_STEPS > 2) ? $clog2(NUM_STEPS) : 1;
    localparam int BOOT   = (BOOT_STEP < NUM_STEPS) ? BOOT_STEP : NUM_STEPS;

    logic [HOLD_W-1:0] start_hold_reg;
    logic [HOLD_W-1:0] pulse_low_reg;
    logic [HOLD_W-1:0] pulse_high_reg;
    logic [HOLD_W-1:0] off_hold_reg;

    logic              is_off_reg;
    logic [STEP_W-1:0] new_step_reg;
    logic [STEP_W-1:0] new_step_next;
    logic [STEP_W-1:0] cur_step_reg;
    logic              driver_on_reg;
    logic [CNT_W-1:0]  pcnt_reg;
    logic [CNT_W-1:0]  pcnt_next;

    logic              act_valid_reg;
    logic              pin_level_reg;
    logic [HOLD_W-1:0] hold_us_reg;
    logic              last_action_reg;
    logic              out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hold_reg <= START_HOLD_RST;
            pulse_low_reg  <= PULSE_LOW_RST;
            pulse_high_reg <= PULSE_HIGH_RST;
            off_hold_reg   <= OFF_HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_HOLD: start_hold_reg <= cfg_data;
                CFG_PULSE_LOW:  pulse_low_reg  <= cfg_data;
                CFG_PULSE_HIGH: pulse_high_reg <= cfg_data;
                CFG_OFF_HOLD:   off_hold_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // brightness to step: thresholds at multiples of the span, highest match wins; steps count down
    always_comb
    begin
        logic [STEP_W-1:0] q;
        q = '0;
        for (int k = 1; k <= NUM_STEPS; k++)
        begin
            if (brightness >= BRIGHT_W'(k * SPAN))
            begin
                q = STEP_W'(k);
            end
        end
        if (q == '0)
        begin
            new_step_next = STEP_W'(NUM_STEPS);
        end
        else if ((q >= STEP_W'(NUM_STEPS)) || (brightness > BRIGHT_W'(FULL_SCALE)))
        begin
            new_step_next = STEP_W'(1);
        end
        else
        begin
            new_step_next = STEP_W'(NUM_STEPS + 1) - q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_off_reg   <= (brightness == '0);
            new_step_reg <= new_step_next;
        end
    end

    // pulse count: wrapping forward distance, or step-1 when waking
    always_comb
    begin
        logic [STEP_W:0] diff;
        if (!driver_on_reg)
        begin
            diff = {1'b0, new_step_reg} - (STEP_W+1)'(1);
        end
        else if (new_step_reg > cur_step_reg)
        begin
            diff = {1'b0, new_step_reg} - {1'b0, cur_step_reg};
        end
        else
        begin
            diff = {1'b0, new_step_reg} + (STEP_W+1)'(NUM_STEPS) - {1'b0, cur_step_reg};
        end
        pcnt_next = diff[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_step_reg  <= STEP_W'(BOOT);
            driver_on_reg <= 1'b1;
        end
        else if (cmd.start)
        begin
            if (is_off_reg)
            begin
                cur_step_reg  <= '0;
                driver_on_reg <= 1'b0;
            end
            else
            begin
                cur_step_reg  <= new_step_reg;
                driver_on_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pcnt_reg <= pcnt_next;
        end
        else if (cmd.act == ACT_HIGH)
        begin
            pcnt_reg <= pcnt_reg - CNT_W'(1);
        end
    end

    // output register
    assign out_free = !act_valid_reg || act_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
        end
        else if (cmd.act != ACT_NONE)
        begin
            act_valid_reg <= 1'b1;
        end
        else if (act_ready)
        begin
            act_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            ACT_OFF:
            begin
                pin_level_reg   <= 1'b0;
                hold_us_reg     <= off_hold_reg;
                last_action_reg <= 1'b1;
            end
            ACT_START:
            begin
                pin_level_reg   <= 1'b1;
                hold_us_reg     <= start_hold_reg;
                last_action_reg <= (pcnt_reg == '0);
            end
            ACT_LOW:
            begin
                pin_level_reg   <= 1'b0;
                hold_us_reg     <= pulse_low_reg;
                last_action_reg <= 1'b0;
            end
            ACT_HIGH:
            begin
                pin_level_reg   <= 1'b1;
                hold_us_reg     <= pulse_high_reg;
                last_action_reg <= (pcnt_reg == CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    assign act_valid   = act_valid_reg;
    assign pin_level   = pin_level_reg;
    assign hold_us     = hold_us_reg;
    assign last_action = last_action_reg;

    assign stat.is_off    = is_off_reg;
    assign stat.unchanged = driver_on_reg && (new_step_reg == cur_step_reg);
    assign stat.was_on    = driver_on_reg;
    assign stat.cnt_zero  = (pcnt_reg == '0);
    assign stat.cnt_one   = (pcnt_reg == CNT_W'(1));
    assign stat.out_free  = out_free;

    `PCBD_ASSERT_IMP(a_no_overwrite, cmd.act != ACT_NONE, out_free)
    `PCBD_ASSERT_IMP(a_off_step_zero, !driver_on_reg, cur_step_reg == '0)
    `PCBD_ASSERT_IMP(a_on_step_range, driver_on_reg, (cur_step_reg != '0) && (cur_step_reg <= STEP_W'(NUM_STEPS)))
    `PCBD_ASSERT_IMP(a_pulse_left, (cmd.act == ACT_LOW) || (cmd.act == ACT_HIGH), pcnt_reg != '0)
    `PCBD_ASSERT_NXT(a_emit_valid, cmd.act != ACT_NONE, act_valid_reg)

endmodule
